// ===== hw/rtl/wsl_pkg.sv =====
`default_nettype none

package wsl_pkg;

  // Field widths
  localparam int unsigned GEN_W     = 2;
  localparam int unsigned COEFF_W   = 24;
  localparam int unsigned WS_W      = 7;
  localparam int unsigned INV_W     = 25;
  localparam int unsigned INV_FRAC  = 24;
  localparam int unsigned STAT_W    = 16;

  // Accumulator widths
  localparam int unsigned COL_W     = 42;
  localparam int unsigned WACC_W    = 48;

  // Window ring
  localparam int unsigned MAX_WIN   = 64;
  localparam int unsigned WIN_AW    = $clog2(MAX_WIN);
  localparam int unsigned RES_W     = $clog2(MAX_WIN / 2);

  // Logistic table: 17 knots, step 0.5 in the argument, 15 fraction bits between knots
  localparam int unsigned SIG_FRAC  = 15;
  localparam int unsigned SIG_IDX_W = 4;
  localparam logic [STAT_W-1:0] SIG_SAT = 16'd65514;

  typedef enum logic [0:0] {
    REG_WINDOW_SIZE     = 1'b0,
    REG_INV_INDIVIDUALS = 1'b1
  } cfg_reg_e;

  // What one column end leaves for the output side
  typedef struct packed {
    logic             first_stat;  // first result carries the statistic
    logic [RES_W-1:0] n_m1;        // results to emit, minus one
    logic             data_end;    // final column: last result gets tlast
  } res_desc_t;

  function automatic logic [WS_W-1:0] ws_eff(input logic [WS_W-1:0] raw);
    logic [WS_W-1:0] v;
    v = raw;
    if (raw == '0) begin
      v = WS_W'(1);
    end else if (raw > WS_W'(MAX_WIN)) begin
      v = WS_W'(MAX_WIN);
    end
    return v;
  endfunction

  function automatic logic [STAT_W-1:0] sig_tab(input logic [SIG_IDX_W:0] idx);
    logic [STAT_W-1:0] v;
    unique case (idx)
      5'd0:    v = 16'd32768;
      5'd1:    v = 16'd40793;
      5'd2:    v = 16'd47911;
      5'd3:    v = 16'd53581;
      5'd4:    v = 16'd57724;
      5'd5:    v = 16'd60565;
      5'd6:    v = 16'd62428;
      5'd7:    v = 16'd63615;
      5'd8:    v = 16'd64357;
      5'd9:    v = 16'd64816;
      5'd10:   v = 16'd65097;
      5'd11:   v = 16'd65269;
      5'd12:   v = 16'd65374;
      5'd13:   v = 16'd65438;
      5'd14:   v = 16'd65476;
      5'd15:   v = 16'd65500;
      default: v = SIG_SAT;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wsl_ram.sv =====
`default_nettype none

module wsl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/wsl_window.sv =====
`default_nettype none

module wsl_window
  import wsl_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = 1048576
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic        [GEN_W-1:0]   genotype_i,
  input  wire logic signed [COEFF_W-1:0] coeff_i,
  input  wire logic                      column_end_i,
  input  wire logic                      data_end_i,
  input  wire logic        [WS_W-1:0]    ws_i,
  input  wire logic        [WS_W-1:0]    ws_next_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic signed      [WACC_W-1:0]  win_o,
  output res_desc_t                      desc_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned PROD_W = COEFF_W + GEN_W + 1;
  localparam int unsigned ASUM_W = COL_W + 1;
  localparam int unsigned WSUM_W = WACC_W + 2;

  // Input register
  logic                      a_valid_q;
  logic        [GEN_W-1:0]   a_gen_q;
  logic signed [COEFF_W-1:0] a_coeff_q;
  logic                      a_cend_q;
  logic                      a_dend_q;

  // Accumulation state
  logic signed [COL_W-1:0]   col_acc_q;
  logic signed [WACC_W-1:0]  win_acc_q;
  logic        [CNT_W-1:0]   cnt_q;
  logic        [WIN_AW-1:0]  rp_q, rp_d;

  // Ring read bypass for a read that hits the word written in the same cycle
  logic                      byp_q;
  logic signed [COL_W-1:0]   byp_data_q;

  // Output register
  logic                      b_valid_q;
  logic signed [WACC_W-1:0]  b_win_q;
  res_desc_t                 b_desc_q;

  logic signed [PROD_W-1:0]  prod;
  logic signed [ASUM_W-1:0]  acc_sum;
  logic signed [COL_W-1:0]   term;
  logic        [COL_W-1:0]   ring_rdata;
  logic signed [COL_W-1:0]   ring_old;
  logic signed [COL_W-1:0]   sub_val;
  logic signed [WSUM_W-1:0]  win_sum;
  logic signed [WACC_W-1:0]  win_sat;
  logic        [WS_W-1:0]    ws_m1, half, tail, n_m1;
  logic                      lead, full, has_res;
  logic                      b_ready, a_go, ring_we;
  logic        [WIN_AW-1:0]  raddr;
  res_desc_t                 desc;

  assign prod    = $signed(a_coeff_q) * $signed({1'b0, a_gen_q});
  assign acc_sum = ASUM_W'(col_acc_q) + ASUM_W'(prod);

  always_comb begin
    term = acc_sum[COL_W-1:0];
    if (acc_sum[ASUM_W-1] != acc_sum[ASUM_W-2]) begin
      term = acc_sum[ASUM_W-1] ? {1'b1, {(COL_W-1){1'b0}}} : {1'b0, {(COL_W-1){1'b1}}};
    end
  end

  assign ring_old = byp_q ? byp_data_q : $signed(ring_rdata);
  assign sub_val  = (cnt_q >= CNT_W'(ws_i)) ? ring_old : '0;
  assign win_sum  = WSUM_W'(win_acc_q) - WSUM_W'(sub_val) + WSUM_W'(term);

  always_comb begin
    win_sat = win_sum[WACC_W-1:0];
    if (!((&win_sum[WSUM_W-1:WACC_W-1]) || !(|win_sum[WSUM_W-1:WACC_W-1]))) begin
      win_sat = win_sum[WSUM_W-1] ? {1'b1, {(WACC_W-1){1'b0}}}
                                   : {1'b0, {(WACC_W-1){1'b1}}};
    end
  end

  // Window geometry: half leads, tail trails the centre position
  assign ws_m1 = ws_i - WS_W'(1);
  assign half  = ws_i >> 1;
  assign tail  = ws_m1 - half;
  assign lead  = cnt_q < CNT_W'(half);
  assign full  = cnt_q >= CNT_W'(ws_m1);

  assign has_res = a_dend_q || lead || full;

  always_comb begin
    n_m1 = '0;
    if (a_dend_q) begin
      priority if (cnt_q <= CNT_W'(half)) begin
        n_m1 = '0;
      end else if (cnt_q <= CNT_W'(ws_m1)) begin
        n_m1 = cnt_q[WS_W-1:0] - half;
      end else begin
        n_m1 = tail;
      end
    end
  end

  always_comb begin
    desc.first_stat = full;
    desc.n_m1       = RES_W'(n_m1);
    desc.data_end   = a_dend_q;
  end

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_go       = a_valid_q && (!(a_cend_q && has_res) || b_ready);
  assign in_ready_o = !a_valid_q || a_go;
  assign ring_we    = a_go && a_cend_q;

  always_comb begin
    rp_d = rp_q;
    if (ring_we) begin
      rp_d = a_dend_q ? '0 : rp_q + WIN_AW'(1);
    end
  end

  // Prefetch the term that leaves the window at the next column end
  assign raddr = rp_d - ws_next_i[WIN_AW-1:0];

  wsl_ram #(
    .WIDTH (COL_W),
    .DEPTH (MAX_WIN)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (rp_q),
    .wdata_i (term),
    .raddr_i (raddr),
    .rdata_o (ring_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      a_gen_q   <= genotype_i;
      a_coeff_q <= coeff_i;
      a_cend_q  <= column_end_i;
      a_dend_q  <= data_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_acc_q <= '0;
      win_acc_q <= '0;
      cnt_q     <= '0;
      rp_q      <= '0;
      byp_q     <= 1'b0;
    end else begin
      rp_q  <= rp_d;
      byp_q <= ring_we && (rp_q == raddr);
      if (a_go) begin
        col_acc_q <= a_cend_q ? '0 : term;
      end
      if (ring_we) begin
        if (a_dend_q) begin
          win_acc_q <= '0;
          cnt_q     <= '0;
        end else begin
          win_acc_q <= win_sat;
          if (cnt_q < CNT_W'(MAX_COLUMNS)) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= term;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= ring_we && has_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && ring_we && has_res) begin
      b_win_q  <= win_sat;
      b_desc_q <= desc;
    end
  end

  assign out_valid_o = b_valid_q;
  assign win_o       = b_win_q;
  assign desc_o      = b_desc_q;

endmodule

`default_nettype wire

// ===== hw/rtl/wsl_logistic.sv =====
`default_nettype none

module wsl_logistic
  import wsl_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [WACC_W-1:0] win_i,
  input  wire res_desc_t                desc_i,
  input  wire logic        [INV_W-1:0]  inv_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic             [STAT_W-1:0] stat_o,
  output res_desc_t                     desc_o
);

  localparam int unsigned HI_W   = WACC_W - INV_FRAC;
  localparam int unsigned PHI_W  = HI_W + INV_W;
  localparam int unsigned PLO_W  = INV_FRAC + INV_W;
  localparam int unsigned LO_W   = PLO_W - INV_FRAC;
  localparam int unsigned A_W    = PHI_W + 1;
  localparam int unsigned IP_W   = STAT_W + SIG_FRAC;
  localparam int unsigned KNOT_B = SIG_IDX_W + SIG_FRAC;

  // Stage after the scaling multiplies
  logic               c_valid_q;
  logic [PHI_W-1:0]   c_phi_q;
  logic [LO_W-1:0]    c_plo_q;
  logic               c_neg_q;
  res_desc_t          c_desc_q;

  // Stage after the interpolation multiply
  logic               d_valid_q;
  logic               d_big_q;
  logic [STAT_W-1:0]  d_base_q;
  logic [IP_W-1:0]    d_ip_q;
  logic               d_neg_q;
  res_desc_t          d_desc_q;

  logic [WACC_W-1:0]  mag;
  logic [PHI_W-1:0]   phi;
  logic [PLO_W-1:0]   plo;
  logic [A_W-1:0]     a_sum;
  logic [SIG_IDX_W-1:0] knot;
  logic [SIG_FRAC-1:0]  frac;
  logic [STAT_W-1:0]  base, step;
  logic [IP_W-1:0]    ip;
  logic [STAT_W-1:0]  v;
  logic [STAT_W:0]    stat_full;
  logic               c_ready, d_ready;

  assign d_ready    = !d_valid_q || out_ready_i;
  assign c_ready    = !c_valid_q || d_ready;
  assign in_ready_o = c_ready;

  assign mag = win_i[WACC_W-1] ? $unsigned(-win_i) : $unsigned(win_i);
  assign phi = mag[WACC_W-1:INV_FRAC] * inv_i;
  assign plo = mag[INV_FRAC-1:0] * inv_i;

  assign a_sum = A_W'(c_phi_q) + A_W'(c_plo_q);
  assign knot  = a_sum[KNOT_B-1:SIG_FRAC];
  assign frac  = a_sum[SIG_FRAC-1:0];
  assign base  = sig_tab({1'b0, knot});
  assign step  = sig_tab({1'b0, knot} + (SIG_IDX_W+1)'(1)) - base;
  assign ip    = step * frac;

  assign v         = d_big_q ? SIG_SAT : d_base_q + STAT_W'(d_ip_q >> SIG_FRAC);
  assign stat_full = d_neg_q ? (STAT_W+1)'(1 << STAT_W) - (STAT_W+1)'(v) : (STAT_W+1)'(v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (c_ready) begin
        c_valid_q <= in_valid_i;
      end
      if (d_ready) begin
        d_valid_q <= c_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && in_valid_i) begin
      c_phi_q  <= phi;
      c_plo_q  <= plo[PLO_W-1:INV_FRAC];
      c_neg_q  <= win_i[WACC_W-1];
      c_desc_q <= desc_i;
    end
    if (d_ready && c_valid_q) begin
      d_big_q  <= |a_sum[A_W-1:KNOT_B];
      d_base_q <= base;
      d_ip_q   <= ip;
      d_neg_q  <= c_neg_q;
      d_desc_q <= c_desc_q;
    end
  end

  assign out_valid_o = d_valid_q;
  assign stat_o      = stat_full[STAT_W-1:0];
  assign desc_o      = d_desc_q;

endmodule

`default_nettype wire

// ===== hw/rtl/wsl_emit.sv =====
`default_nettype none

module wsl_emit
  import wsl_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [STAT_W-1:0] stat_i,
  input  wire res_desc_t         desc_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [STAT_W-1:0] out_stat_o,
  output logic                   out_missing_o,
  output logic                   out_last_o
);

  logic              e_valid_q;
  logic [STAT_W-1:0] e_stat_q;
  logic              e_is_stat_q;
  logic [RES_W-1:0]  e_rem_q;
  logic              e_end_q;

  assign in_ready_o = !e_valid_q || (out_ready_i && (e_rem_q == '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q   <= 1'b0;
      e_rem_q     <= '0;
      e_is_stat_q <= 1'b0;
      e_end_q     <= 1'b0;
    end else if (in_ready_o) begin
      e_valid_q <= in_valid_i;
      if (in_valid_i) begin
        e_rem_q     <= desc_i.n_m1;
        e_is_stat_q <= desc_i.first_stat;
        e_end_q     <= desc_i.data_end;
      end
    end else if (out_ready_i) begin
      // advance through the trailing missing markers
      e_rem_q     <= e_rem_q - RES_W'(1);
      e_is_stat_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      e_stat_q <= stat_i;
    end
  end

  assign out_valid_o   = e_valid_q;
  assign out_stat_o    = e_is_stat_q ? e_stat_q : '0;
  assign out_missing_o = !e_is_stat_q;
  assign out_last_o    = e_end_q && (e_rem_q == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/window_sum_logistic_unit.sv =====
// Channel   Direction  Payload
// s_axis    in         tdata: genotype, coeff; tlast: column end; tuser: data end
// m_axis    out        tdata: stat; tlast: last result of matrix; tuser: missing
// cfg       in         write only: 0 window size, 1 reciprocal of individual count
//
// One item is accepted per cycle while s_axis_tready is high. A column end passes through
// the stages window sum, scaling multiply, interpolation multiply and output.
// The final column yields up to 32 results, one per cycle from the output register
// while m_axis_tready is high; meanwhile up to four more items fill the stages behind it.
// Reset clears the stages and the accumulators and loads window size 2, scale 1.0;
// the 64-entry term ring is not cleared.
`default_nettype none

module window_sum_logistic_unit
  import wsl_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = 1048576
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [31:0]       s_axis_tdata_i,   // [1:0] genotype, [25:2] coeff
  input  wire logic              s_axis_tlast_i,   // column end
  input  wire logic              s_axis_tuser_i,   // data end
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic [STAT_W-1:0]      m_axis_tdata_o,   // [15:0] stat
  output logic                   m_axis_tlast_o,   // last
  output logic                   m_axis_tuser_o,   // missing
  input  wire logic              cfg_we_i,
  input  wire logic [0:0]        cfg_addr_i,
  input  wire logic [INV_W-1:0]  cfg_data_i
);

  logic [WS_W-1:0]   ws_q, ws_d;
  logic [INV_W-1:0]  inv_q, inv_d;

  logic                      win_valid, win_ready;
  logic signed [WACC_W-1:0]  win;
  res_desc_t                 win_desc;

  logic              lg_valid, lg_ready;
  logic [STAT_W-1:0] lg_stat;
  res_desc_t         lg_desc;

  always_comb begin
    ws_d  = ws_q;
    inv_d = inv_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_WINDOW_SIZE:     ws_d  = cfg_data_i[WS_W-1:0];
        REG_INV_INDIVIDUALS: inv_d = cfg_data_i;
        default:             ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q  <= WS_W'(2);
      inv_q <= INV_W'(1 << INV_FRAC);
    end else begin
      ws_q  <= ws_d;
      inv_q <= inv_d;
    end
  end

  wsl_window #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .genotype_i   (s_axis_tdata_i[GEN_W-1:0]),
    .coeff_i      ($signed(s_axis_tdata_i[GEN_W+COEFF_W-1:GEN_W])),
    .column_end_i (s_axis_tlast_i),
    .data_end_i   (s_axis_tuser_i),
    .ws_i         (ws_eff(ws_q)),
    .ws_next_i    (ws_eff(ws_d)),
    .out_valid_o  (win_valid),
    .out_ready_i  (win_ready),
    .win_o        (win),
    .desc_o       (win_desc)
  );

  wsl_logistic u_logistic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (win_valid),
    .in_ready_o  (win_ready),
    .win_i       (win),
    .desc_i      (win_desc),
    .inv_i       (inv_q),
    .out_valid_o (lg_valid),
    .out_ready_i (lg_ready),
    .stat_o      (lg_stat),
    .desc_o      (lg_desc)
  );

  wsl_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (lg_valid),
    .in_ready_o    (lg_ready),
    .stat_i        (lg_stat),
    .desc_i        (lg_desc),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_stat_o    (m_axis_tdata_o),
    .out_missing_o (m_axis_tuser_o),
    .out_last_o    (m_axis_tlast_o)
  );

  // A missing marker never carries a statistic
  a_missing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("missing marker with nonzero stat");

  // A statistic handed to the output stage appears first, not as a marker
  a_stat_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lg_valid && lg_ready && lg_desc.first_stat |=> m_axis_tvalid_o && !m_axis_tuser_o)
    else $error("statistic lost at output stage");

  // Within a run of results the next one follows as a missing marker
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !lg_ready |=> m_axis_tvalid_o && m_axis_tuser_o)
    else $error("result run broken");

endmodule

`default_nettype wire

// ===== test/window_sum_logistic_unit_test.sv =====
`timescale 1ns / 100ps

module window_sum_logistic_unit_test;
  import wsl_pkg::*;

  // Small column limit so that the count saturation is reachable in a short run
  localparam int unsigned COL_LIMIT    = 64;
  localparam int unsigned TOTAL_ITEMS  = 320;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned LINGER       = 40;
  localparam int unsigned STALL_LIMIT  = 2000;

  // Logistic knots at steps of 0.5 in the argument, Q0.16
  localparam int unsigned KNOT [0:16] = '{
    32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615, 64357,
    64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514
  };

  // Config settings walked by the random part, extremes first
  localparam int unsigned PHASE_WS  [0:7] = '{1, 127, 0, 3, 64, 2, 33, 5};
  localparam int unsigned PHASE_INV [0:7] = '{
    16777216, 33554431, 0, 65536, 16777216, 1, 1048576, 4096
  };

  typedef struct packed {
    logic [GEN_W-1:0]   geno;
    logic [COEFF_W-1:0] coeff;
    logic               col_end;
    logic               data_end;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0] stat;
    logic              missing;
    logic              last;
  } res_t;

  typedef struct packed {
    item_t it;
    logic  typed;
    res_t  want;
  } row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid_i;
  logic               s_axis_tready_o;
  logic [31:0]        s_axis_tdata_i;   // [1:0] genotype, [25:2] coeff
  logic               s_axis_tlast_i;   // column end
  logic               s_axis_tuser_i;   // data end
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i;
  logic [STAT_W-1:0]  m_axis_tdata_o;   // [15:0] stat
  logic               m_axis_tlast_o;   // last
  logic               m_axis_tuser_o;   // missing
  logic               cfg_we_i;
  logic [0:0]         cfg_addr_i;
  logic [INV_W-1:0]   cfg_data_i;

  // Predictor state
  logic [WS_W-1:0]           ws_reg   = WS_W'(2);
  logic [INV_W-1:0]          inv_reg  = INV_W'(16777216);
  longint                    col_acc  = 0;
  longint                    win_acc  = 0;
  logic signed [COL_W-1:0]   term_ring [MAX_WIN];
  int unsigned               col_cnt  = 0;
  int unsigned               ring_ptr = 0;

  res_t        fresh_stats[$];
  res_t        stat_q[$];
  row_t        dir_rows[$];
  int unsigned items_sent  = 0;
  int unsigned fail_count  = 0;
  int unsigned no_gap_run  = 0;
  int unsigned quiet_cycles = 0;

  window_sum_logistic_unit #(
    .MAX_COLUMNS(COL_LIMIT)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint saturate(input longint v, input int unsigned w);
    longint lim;
    lim = longint'(1) << (w - 1);
    if (v > lim - 1) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic int unsigned eff_window(input int unsigned raw);
    if (raw == 0) return 1;
    if (raw > MAX_WIN) return MAX_WIN;
    return raw;
  endfunction

  function automatic logic [STAT_W-1:0] logistic_q16(input longint acc,
                                                     input logic [INV_W-1:0] scale);
    logic [63:0] mag;
    logic [63:0] a;
    logic [63:0] seg;
    longint      lo;
    longint      hi;
    longint      v;
    mag = (acc < 0) ? 64'(-acc) : 64'(acc);
    a = (mag >> INV_FRAC) * 64'(scale) + (((mag & 64'hFF_FFFF) * 64'(scale)) >> INV_FRAC);
    seg = a >> SIG_FRAC;
    if (seg >= 16) begin
      v = KNOT[16];
    end else begin
      lo = KNOT[seg];
      hi = KNOT[seg + 1];
      v = lo + (((hi - lo) * longint'(a & 64'h7FFF)) >> SIG_FRAC);
    end
    if (acc < 0) v = 65536 - v;
    return v[STAT_W-1:0];
  endfunction

  // Fold one item into the column and window sums; leave its results in fresh_stats
  function automatic void predict_window_stats(input item_t it);
    int unsigned       eff;
    int unsigned       h;
    int unsigned       t;
    int unsigned       c;
    int unsigned       from;
    longint            term;
    logic [STAT_W-1:0] st;
    bit                full;
    fresh_stats.delete();
    col_acc = saturate(col_acc + longint'($signed(it.coeff)) * longint'(it.geno), COL_W);
    if (!it.col_end) return;
    eff = eff_window(ws_reg);
    h = eff / 2;
    t = eff - 1 - h;
    c = col_cnt;
    term = col_acc;
    col_acc = 0;
    if (c >= eff) win_acc = win_acc - longint'(term_ring[(ring_ptr + MAX_WIN - eff) % MAX_WIN]);
    win_acc = saturate(win_acc + term, WACC_W);
    term_ring[ring_ptr] = COL_W'(term);
    ring_ptr = (ring_ptr + 1) % MAX_WIN;
    if (col_cnt < COL_LIMIT) col_cnt++;
    full = (c >= eff - 1);
    st = full ? logistic_q16(win_acc, inv_reg) : '0;
    if (!it.data_end) begin
      if (c < h) fresh_stats.push_back({STAT_W'(0), 1'b1, 1'b0});
      else if (full) fresh_stats.push_back({st, 1'b0, 1'b0});
      return;
    end
    // Final column: flush every position still owed, then start a new matrix
    if (c <= h) from = c;
    else if (c <= eff - 1) from = h;
    else from = c - t;
    for (int unsigned p = from; p <= c; p++) begin
      if (full && p == c - t) fresh_stats.push_back({st, 1'b0, p == c});
      else fresh_stats.push_back({STAT_W'(0), 1'b1, p == c});
    end
    win_acc = 0;
    col_cnt = 0;
    ring_ptr = 0;
  endfunction

  function automatic void add_row(input int g, input int k, input bit ce, input bit de,
                                  input bit typed, input int st, input bit miss,
                                  input bit lst);
    row_t row;
    row.it = {GEN_W'(g), COEFF_W'(k), ce, de};
    row.typed = typed;
    row.want = {STAT_W'(st), miss, lst};
    dir_rows.push_back(row);
  endfunction

  function automatic logic [COEFF_W-1:0] pick_coeff();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return COEFF_W'(int'($urandom_range(0, 65535)) - 32768);
    if (r < 85) return COEFF_W'(int'($urandom_range(0, 524287)) - 262144);
    return COEFF_W'($urandom());
  endfunction

  task automatic send_item(input item_t it, input bit typed, input res_t want);
    int unsigned gap;
    int          r;
    gap = 0;
    if (no_gap_run > 0) begin
      no_gap_run--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 8) no_gap_run = $urandom_range(10, 40);
      else if (r < 55) gap = 0;
      else if (r < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 30);
    end
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'b0, it.coeff, it.geno};
    s_axis_tlast_i  <= it.col_end;
    s_axis_tuser_i  <= it.data_end;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
    predict_window_stats(it);
    if (typed) begin
      stat_q.push_back(want);
    end else begin
      foreach (fresh_stats[i]) stat_q.push_back(fresh_stats[i]);
    end
  endtask

  // Hold the input until every expected result is out and the pipeline is empty
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (stat_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [INV_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_WINDOW_SIZE) ws_reg = val[WS_W-1:0];
    else inv_reg = val;
    @(posedge clk_i);
  endtask

  task automatic run_matrix(input int n_cols, input int max_rows, input bit shift_window);
    item_t              it;
    int                 rows;
    logic [COEFF_W-1:0] k;
    for (int col = 0; col < n_cols; col++) begin
      if (shift_window && col == n_cols / 2) begin
        drain_results();
        write_reg(REG_WINDOW_SIZE, INV_W'($urandom_range(0, 127)));
      end
      rows = $urandom_range(1, max_rows);
      k = pick_coeff();
      for (int r = 0; r < rows; r++) begin
        it.geno = ($urandom_range(0, 9) == 0) ? 2'd3 : GEN_W'($urandom_range(0, 2));
        it.coeff = k;
        it.col_end = (r == rows - 1);
        it.data_end = it.col_end ? (col == n_cols - 1) : ($urandom_range(0, 9) == 0);
        send_item(it, 1'b0, '0);
      end
    end
  endtask

  // Receiver: runs of ready and stalls, short and long
  initial begin
    int unsigned hold;
    bit          stall;
    int          r;
    hold = 0;
    stall = 1'b0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          stall = 1'b0;
          hold = $urandom_range(1, 20);
        end else if (r < 80) begin
          stall = 1'b1;
          hold = $urandom_range(1, 3);
        end else if (r < 95) begin
          stall = 1'b0;
          hold = $urandom_range(30, 100);
        end else begin
          stall = 1'b1;
          hold = $urandom_range(10, 40);
        end
      end
      m_axis_tready_i <= !stall;
    end
  end

  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (stat_q.size() == 0) begin
        $error("unexpected result: stat %0d missing %0d last %0d",
               m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        fail_count++;
      end else begin
        want = stat_q.pop_front();
        if (m_axis_tdata_o !== want.stat) begin
          $error("stat: expected %0d, got %0d", want.stat, m_axis_tdata_o);
          fail_count++;
        end
        if (m_axis_tuser_o !== want.missing) begin
          $error("missing: expected %0d, got %0d", want.missing, m_axis_tuser_o);
          fail_count++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_axis_tlast_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned ws;
    int unsigned inv;
    int unsigned e;
    int unsigned n_mat;
    int unsigned nc;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    s_axis_tuser_i  = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_addr_i      = REG_WINDOW_SIZE;
    cfg_data_i      = '0;

    // Reset values: window 2, scale 1.0
    //      geno coeff      ce  de  typed stat   miss last
    add_row(0,   0,         1,  0,  1,    0,     1,   0);  // leading edge marker
    add_row(3,   8388607,   0,  0,  0,    0,     0,   0);
    add_row(3,   8388607,   0,  1,  0,    0,     0,   0);  // data end without column end
    add_row(2,   -8388608,  1,  0,  1,    65514, 0,   0);  // saturated logistic
    add_row(1,   -8388608,  1,  1,  1,    65514, 0,   1);
    add_row(2,   -8388608,  1,  0,  1,    0,     1,   0);
    add_row(2,   -8388608,  1,  1,  1,    22,    0,   1);  // negative extreme
    add_row(1,   5,         1,  1,  1,    0,     1,   1);  // short matrix
    add_row(1,   1000,      0,  0,  0,    0,     0,   0);
    add_row(3,   20000,     1,  0,  1,    0,     1,   0);
    add_row(2,   -30000,    1,  0,  0,    0,     0,   0);
    add_row(0,   -1,        0,  1,  0,    0,     0,   0);
    add_row(1,   70000,     1,  0,  0,    0,     0,   0);
    add_row(2,   -100000,   1,  1,  0,    0,     0,   0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      drain_results();
      if (phase < 8) begin
        ws = PHASE_WS[phase];
        inv = PHASE_INV[phase];
      end else begin
        ws = $urandom_range(1, 10);
        inv = ($urandom_range(0, 3) == 0) ? 16777216 : $urandom_range(1024, 16777216);
      end
      write_reg(REG_WINDOW_SIZE, INV_W'(ws));
      write_reg(REG_INV_INDIVIDUALS, INV_W'(inv));
      e = eff_window(ws);
      n_mat = $urandom_range(2, 4);
      for (int m = 0; m < n_mat; m++) begin
        if (m == 0 && e >= 32) begin
          // long matrix: reaches full windows of large size and the count limit
          run_matrix(COL_LIMIT + $urandom_range(1, 8), 1, 1'b0);
        end else begin
          nc = $urandom_range(1, (e + 3 > 8) ? 8 : e + 3);
          run_matrix(nc, 3, nc >= 2 && $urandom_range(0, 7) == 0);
        end
      end
      phase++;
    end

    s_axis_tvalid_i <= 1'b0;
    while (stat_q.size() != 0) @(posedge clk_i);
    repeat (LINGER) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
